// File: rtl/multi_button_lockout_debouncer_macros.svh
// ----------------------------------------------------------------------------
// Multi-button lockout debouncer assertion macros
// Shared assertion wrappers for the debouncer RTL.
// ----------------------------------------------------------------------------
`ifndef MULTI_BUTTON_LOCKOUT_DEBOUNCER_MACROS_SVH
`define MULTI_BUTTON_LOCKOUT_DEBOUNCER_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define MBLD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check, with the implication written out by the macro.
`define MBLD_ASSERT_IMPL(label, ante, cons, msg) \
  `MBLD_ASSERT(label, (ante) |-> (cons), msg)

`endif

// File: rtl/mbld_pkg.sv
// ----------------------------------------------------------------------------
// Debouncer package
// Field widths, item kinds and per-button state types.
// ----------------------------------------------------------------------------
package mbld_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned ButtonW = 3;
  localparam int unsigned TimeW   = 32;

  localparam logic [TimeW-1:0] BounceTicksReset = 32'd50;

  typedef enum logic [KindW-1:0] {
    KIND_SAMPLE     = 2'd0,
    KIND_QUERY_LOW  = 2'd1,
    KIND_QUERY_HIGH = 2'd2,
    KIND_ARM        = 2'd3
  } kind_e;

  typedef struct packed {
    logic             armed;
    logic             last_level;
    logic             low_mark;
    logic             high_mark;
    logic [TimeW-1:0] change_time;
  } btn_state_t;

  typedef struct packed {
    logic stable_level;
    logic edge_seen;
  } step_res_t;

endpackage

// File: rtl/mbld_step.sv
// ----------------------------------------------------------------------------
// Debouncer step
// Next state and result for one button entry and one item.
// ----------------------------------------------------------------------------
module mbld_step (
  input  mbld_pkg::kind_e              kind_i,
  input  logic                         level_i,
  input  logic [mbld_pkg::TimeW-1:0]   now_i,
  input  logic [mbld_pkg::TimeW-1:0]   bounce_ticks_i,
  input  mbld_pkg::btn_state_t         state_i,
  output mbld_pkg::btn_state_t         state_o,
  output mbld_pkg::step_res_t          result_o
);
  import mbld_pkg::*;

  logic [TimeW-1:0] age;
  logic             take_change;
  logic             new_level;

  // The age wraps modulo 2^32, as the time base does.
  assign age         = now_i - state_i.change_time;
  assign take_change = (level_i != state_i.last_level) && (age >= bounce_ticks_i);
  assign new_level   = take_change ? level_i : state_i.last_level;

  always_comb begin
    state_o               = state_i;
    result_o.stable_level = 1'b1;
    result_o.edge_seen    = 1'b0;
    if (kind_i == KIND_ARM) begin
      state_o.armed         = 1'b1;
      state_o.last_level    = level_i;
      state_o.low_mark      = level_i;
      state_o.high_mark     = level_i;
      state_o.change_time   = '0;
      result_o.stable_level = level_i;
    end else if (state_i.armed) begin
      state_o.last_level    = new_level;
      state_o.change_time   = take_change ? now_i : state_i.change_time;
      result_o.stable_level = new_level;
      case (kind_i)
        KIND_QUERY_LOW: begin
          result_o.edge_seen = !new_level && state_i.low_mark;
          state_o.low_mark   = new_level;
        end
        KIND_QUERY_HIGH: begin
          result_o.edge_seen = new_level && !state_i.high_mark;
          state_o.high_mark  = new_level;
        end
        default: begin
          result_o.edge_seen = 1'b0;
        end
      endcase
    end
  end

endmodule

// File: rtl/multi_button_lockout_debouncer.sv
// ----------------------------------------------------------------------------
// Multi-button lockout debouncer
// Per-button lockout debouncing with arm, sample and edge queries.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  in       input      in_valid_i / in_ready_o   kind_i, button_i, level_i, now_i
//  out      output     out_valid_o / out_ready_i stable_level_o, edge_seen_o
//  cfg      input      cfg_we_i                  cfg_data_i (bounce_ticks)
//
// One item per cycle is sustained while the output is not stalled; the result
// register is loaded from the input register when stage 1 advances.
// The button table is in flip-flops and is read and written back in the same
// cycle, so each item sees the state left by the one before it.
// Reset clears the table to unarmed buttons and sets bounce_ticks to 50.
// A stalled output holds the result register and any item in the input register.
// ----------------------------------------------------------------------------
module multi_button_lockout_debouncer #(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mbld_pkg::TimeW-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mbld_pkg::KindW-1:0]     kind_i,
  input  logic [mbld_pkg::ButtonW-1:0]   button_i,
  input  logic                           level_i,
  input  logic [mbld_pkg::TimeW-1:0]     now_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           stable_level_o,
  output logic                           edge_seen_o
);
  import mbld_pkg::*;

  `include "multi_button_lockout_debouncer_macros.svh"

  logic [TimeW-1:0]         bounce_ticks_q;

  logic                     s1_valid_q;
  kind_e                    s1_kind_q;
  logic [ButtonW-1:0]       s1_button_q;
  logic                     s1_level_q;
  logic [TimeW-1:0]         s1_now_q;
  logic                     s1_adv;

  logic [NUM_BUTTONS-1:0]   armed_q;
  logic [NUM_BUTTONS-1:0]   level_q;
  logic [NUM_BUTTONS-1:0]   low_q;
  logic [NUM_BUTTONS-1:0]   high_q;
  logic [TimeW-1:0]         ctime_q [NUM_BUTTONS];

  logic [NUM_BUTTONS-1:0]   hit;
  logic                     in_range;
  btn_state_t               rd_state;
  btn_state_t               wr_state;
  step_res_t                step_res;

  logic                     out_valid_q;
  logic                     out_stable_q;
  logic                     out_edge_q;

  // Stage 1 moves on when the result register is free or being drained.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounce_ticks_q <= BounceTicksReset;
    end else if (cfg_we_i) begin
      bounce_ticks_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_kind_q   <= kind_e'(kind_i);
      s1_button_q <= button_i;
      s1_level_q  <= level_i;
      s1_now_q    <= now_i;
    end
  end

  // Decode the button into a select line; indexes past the table hit nothing.
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      hit[i] = (32'(s1_button_q) == 32'(i));
    end
  end
  assign in_range = |hit;

  always_comb begin
    rd_state = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (hit[i]) begin
        rd_state.armed       = armed_q[i];
        rd_state.last_level  = level_q[i];
        rd_state.low_mark    = low_q[i];
        rd_state.high_mark   = high_q[i];
        rd_state.change_time = ctime_q[i];
      end
    end
  end

  mbld_step u_step (
    .kind_i         (s1_kind_q),
    .level_i        (s1_level_q),
    .now_i          (s1_now_q),
    .bounce_ticks_i (bounce_ticks_q),
    .state_i        (rd_state),
    .state_o        (wr_state),
    .result_o       (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
      level_q <= '1;
      low_q   <= '1;
      high_q  <= '1;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        ctime_q[i] <= '0;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (hit[i]) begin
          armed_q[i] <= wr_state.armed;
          level_q[i] <= wr_state.last_level;
          low_q[i]   <= wr_state.low_mark;
          high_q[i]  <= wr_state.high_mark;
          ctime_q[i] <= wr_state.change_time;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_stable_q <= in_range ? step_res.stable_level : 1'b1;
      out_edge_q   <= in_range ? step_res.edge_seen : 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign stable_level_o = out_stable_q;
  assign edge_seen_o    = out_edge_q;

  `MBLD_ASSERT_IMPL(a_sel_onehot, s1_valid_q, $onehot0(hit), "button select is not one-hot")
  `MBLD_ASSERT_IMPL(a_ready_when_empty, !out_valid_q, in_ready_o, "input blocked while output empty")
  `MBLD_ASSERT(a_table_hold, !s1_adv |=> $stable(armed_q) && $stable(level_q), "button table changed without a transfer")
  `MBLD_ASSERT(a_arm_result, s1_adv && in_range && s1_kind_q == KIND_ARM |=> out_stable_q == $past(s1_level_q), "arm result differs from armed level")

endmodule

// File: tb/sv/tb_multi_button_lockout_debouncer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-button lockout debouncer testbench
// Runs a directed table and then random sample, query and arm transfers
// through the debouncer. Each accepted input is run through a local model of
// the button table, and every output transfer is compared with the oldest
// expected result. Both handshake sides idle at random, and the lockout time
// is changed between phases while the block is empty.
// ----------------------------------------------------------------------------
module tb_multi_button_lockout_debouncer;
  import mbld_pkg::*;

  localparam int unsigned NumButtons = 8;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumPhases  = 6;

  typedef struct packed {
    bit                 is_cfg;
    kind_e              kind;
    logic [ButtonW-1:0] button;
    logic               level;
    logic [TimeW-1:0]   value;
    bit                 typed;
    logic               exp_level;
    logic               exp_edge;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [TimeW-1:0]    cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [KindW-1:0]    kind_i       = '0;
  logic [ButtonW-1:0]  button_i     = '0;
  logic                level_i      = 1'b0;
  logic [TimeW-1:0]    now_i        = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic                stable_level_o;
  logic                edge_seen_o;

  // Local copy of the button table and the lockout register.
  logic                btn_armed       [NumButtons];
  logic                btn_level       [NumButtons];
  logic                btn_low_mark    [NumButtons];
  logic                btn_high_mark   [NumButtons];
  logic [TimeW-1:0]    btn_change_time [NumButtons];
  logic [TimeW-1:0]    bounce_ticks_q  = BounceTicksReset;

  step_res_t           expected_results [$];
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count    = 0;
  int unsigned         send_idle_pct  = 14;
  int unsigned         recv_idle_pct  = 71;
  bit                  stall_req      = 1'b0;
  int unsigned         stall_left     = 0;
  logic [TimeW-1:0]    tick_now       = '0;

  stim_row_t directed_rows [23] = '{
    '{1'b0, KIND_QUERY_HIGH, 3'd5, 1'b0, 32'h0000_0000, 1'b1, 1'b1, 1'b0},
    '{1'b0, KIND_SAMPLE,     3'd7, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
    '{1'b0, KIND_ARM,        3'd0, 1'b0, 32'h0000_0000, 1'b1, 1'b0, 1'b0},
    '{1'b0, KIND_SAMPLE,     3'd0, 1'b1, 32'd49,        1'b0, 1'b0, 1'b0},
    '{1'b0, KIND_SAMPLE,     3'd0, 1'b1, 32'd50,        1'b0, 1'b0, 1'b0},
    '{1'b0, KIND_QUERY_HIGH, 3'd0, 1'b1, 32'd51,        1'b0, 1'b0, 1'b0},
    '{1'b0, KIND_QUERY_HIGH, 3'd0, 1'b1, 32'd52,        1'b0, 1'b0, 1'b0},
    '{1'b0, KIND_QUERY_LOW,  3'd0, 1'b0, 32'd60,        1'b0, 1'b0, 1'b0},
    '{1'b0, KIND_QUERY_LOW,  3'd0, 1'b0, 32'd100,       1'b0, 1'b0, 1'b0},
    '{1'b0, KIND_ARM,        3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
    // The elapsed time wraps past zero on the second of the next two samples.
    '{1'b0, KIND_SAMPLE,     3'd7, 1'b0, 32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0},
    '{1'b0, KIND_SAMPLE,     3'd7, 1'b1, 32'h0000_0005, 1'b0, 1'b0, 1'b0},
    '{1'b0, KIND_QUERY_HIGH, 3'd7, 1'b1, 32'h0000_0022, 1'b0, 1'b0, 1'b0},
    '{1'b0, KIND_ARM,        3'd0, 1'b1, 32'h1234_5678, 1'b1, 1'b1, 1'b0},
    '{1'b1, KIND_SAMPLE,     3'd0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{1'b0, KIND_SAMPLE,     3'd0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{1'b0, KIND_SAMPLE,     3'd0, 1'b1, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{1'b0, KIND_QUERY_LOW,  3'd0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{1'b1, KIND_SAMPLE,     3'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
    '{1'b0, KIND_ARM,        3'd3, 1'b0, 32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0},
    '{1'b0, KIND_SAMPLE,     3'd3, 1'b1, 32'hFFFF_FFFE, 1'b0, 1'b0, 1'b0},
    '{1'b0, KIND_QUERY_HIGH, 3'd3, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
    '{1'b0, KIND_QUERY_LOW,  3'd2, 1'b1, 32'h5555_5555, 1'b1, 1'b1, 1'b0}
  };

  multi_button_lockout_debouncer #(
    .NUM_BUTTONS(NumButtons)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .button_i      (button_i),
    .level_i       (level_i),
    .now_i         (now_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .stable_level_o(stable_level_o),
    .edge_seen_o   (edge_seen_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < NumButtons; i++) begin
      btn_armed[i]       = 1'b0;
      btn_level[i]       = 1'b1;
      btn_low_mark[i]    = 1'b1;
      btn_high_mark[i]   = 1'b1;
      btn_change_time[i] = '0;
    end
  end

  // Applies one item to the local button table and returns its result.
  function automatic step_res_t debounce_step(input kind_e k, input logic [ButtonW-1:0] b,
                                              input logic lvl, input logic [TimeW-1:0] t);
    step_res_t        r;
    logic [TimeW-1:0] age;
    r.stable_level = 1'b1;
    r.edge_seen    = 1'b0;
    if (k == KIND_ARM) begin
      btn_armed[b]       = 1'b1;
      btn_level[b]       = lvl;
      btn_low_mark[b]    = lvl;
      btn_high_mark[b]   = lvl;
      btn_change_time[b] = '0;
      r.stable_level     = lvl;
    end else if (btn_armed[b]) begin
      age = t - btn_change_time[b];
      if (lvl != btn_level[b] && age >= bounce_ticks_q) begin
        btn_level[b]       = lvl;
        btn_change_time[b] = t;
      end
      r.stable_level = btn_level[b];
      case (k)
        KIND_QUERY_LOW: begin
          r.edge_seen     = !btn_level[b] && btn_low_mark[b];
          btn_low_mark[b] = btn_level[b];
        end
        KIND_QUERY_HIGH: begin
          r.edge_seen      = btn_level[b] && !btn_high_mark[b];
          btn_high_mark[b] = btn_level[b];
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // Called on a rising edge; returns on the edge of the transfer or after the idle gap.
  task automatic drive_item(input kind_e k, input logic [ButtonW-1:0] b, input logic lvl,
                            input logic [TimeW-1:0] t, input bit typed,
                            input step_res_t typed_res);
    step_res_t res;
    in_valid_i <= 1'b1;
    kind_i     <= k;
    button_i   <= b;
    level_i    <= lvl;
    now_i      <= t;
    do @(posedge clk_i); while (!in_ready_o);
    res = debounce_step(k, b, lvl, t);
    expected_results.push_back(typed ? typed_res : res);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  // The block must be empty before the lockout time changes.
  task automatic set_bounce(input logic [TimeW-1:0] v);
    while (expected_results.size() != 0) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    bounce_ticks_q  = v;
  endtask

  task automatic random_item();
    logic [ButtonW-1:0] b;
    kind_e              k;
    logic               lvl;
    logic [TimeW-1:0]   t;
    int unsigned        pick;
    b    = ButtonW'($urandom_range(0, NumButtons - 1));
    pick = $urandom_range(0, 99);
    // Unarmed buttons are mostly armed so that the deeper behavior is reached.
    if (!btn_armed[b]) begin
      k = (pick < 70) ? KIND_ARM : kind_e'($urandom_range(0, 2));
    end else if (pick < 8) begin
      k = KIND_ARM;
    end else if (pick < 54) begin
      k = KIND_SAMPLE;
    end else if (pick < 77) begin
      k = KIND_QUERY_LOW;
    end else begin
      k = KIND_QUERY_HIGH;
    end
    lvl  = ($urandom_range(0, 99) < 65) ? !btn_level[b] : 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      tick_now = tick_now + $urandom_range(0, 30);
      t        = tick_now;
    end else if (pick < 80) begin
      // Land right around the end of the lockout window.
      t = btn_change_time[b] + bounce_ticks_q + $urandom_range(0, 4) - 2;
    end else if (pick < 90) begin
      t = $urandom;
    end else begin
      t = tick_now;
    end
    drive_item(k, b, lvl, t, 1'b0, '0);
  endtask

  // Receiver side, with an occasional long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        stall_left = 60;
        stall_req  = 1'b0;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    step_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("ERROR: output transfer with no result expected: level %b edge %b",
                   stable_level_o, edge_seen_o);
        end
      end else begin
        want = expected_results.pop_front();
        if (want.stable_level !== stable_level_o || want.edge_seen !== edge_seen_o) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("ERROR: expected level %b edge %b, got level %b edge %b",
                     want.stable_level, want.edge_seen, stable_level_o, edge_seen_o);
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    logic [TimeW-1:0] phase_bounce [NumPhases];
    int unsigned      phase_items  [NumPhases];
    step_res_t        typed_res;
    phase_bounce = '{32'd0, 32'd13, 32'hFFFF_FFFF, 32'd0, 32'd50, 32'd7};
    phase_items  = '{90, 90, 90, 90, 100, 90};
    phase_bounce[3] = $urandom_range(1, 200);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        in_valid_i <= 1'b0;
        set_bounce(directed_rows[i].value);
      end else begin
        typed_res.stable_level = directed_rows[i].exp_level;
        typed_res.edge_seen    = directed_rows[i].exp_edge;
        drive_item(directed_rows[i].kind, directed_rows[i].button, directed_rows[i].level,
                   directed_rows[i].value, directed_rows[i].typed, typed_res);
      end
    end
    in_valid_i <= 1'b0;

    for (int p = 0; p < NumPhases; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // The sender waits for every result before the lockout time changes.
      set_bounce(phase_bounce[p]);
      if (p == 1 || p == 4) stall_req = 1'b1;
      repeat (phase_items[p]) random_item();
      in_valid_i <= 1'b0;
    end

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
